FILE: rtl/mcs_pkg.sv
package mcs_pkg;

  // ASCII codes used by the codec
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Longest code in the table
  localparam int unsigned CODE_MAX_LEN = 5;
  localparam int unsigned NUM_CODES    = 36;

  // One code table entry: bit i of pat set means a dash at place i
  typedef struct packed {
    logic [7:0] ch;
    logic [2:0] len;
    logic [4:0] pat;
  } code_ent_t;

  localparam code_ent_t CODE_TAB [NUM_CODES] = '{
    '{8'h41, 3'd2, 5'b00010}, '{8'h42, 3'd4, 5'b00001}, '{8'h43, 3'd4, 5'b00101},
    '{8'h44, 3'd3, 5'b00001}, '{8'h45, 3'd1, 5'b00000}, '{8'h46, 3'd4, 5'b00100},
    '{8'h47, 3'd3, 5'b00011}, '{8'h48, 3'd4, 5'b00000}, '{8'h49, 3'd2, 5'b00000},
    '{8'h4A, 3'd4, 5'b01110}, '{8'h4B, 3'd3, 5'b00101}, '{8'h4C, 3'd4, 5'b00010},
    '{8'h4D, 3'd2, 5'b00011}, '{8'h4E, 3'd2, 5'b00001}, '{8'h4F, 3'd3, 5'b00111},
    '{8'h50, 3'd4, 5'b00110}, '{8'h51, 3'd4, 5'b01011}, '{8'h52, 3'd3, 5'b00010},
    '{8'h53, 3'd3, 5'b00000}, '{8'h54, 3'd1, 5'b00001}, '{8'h55, 3'd3, 5'b00100},
    '{8'h56, 3'd4, 5'b01000}, '{8'h57, 3'd3, 5'b00110}, '{8'h58, 3'd4, 5'b01001},
    '{8'h59, 3'd4, 5'b01101}, '{8'h5A, 3'd4, 5'b00011}, '{8'h30, 3'd5, 5'b11111},
    '{8'h31, 3'd5, 5'b11110}, '{8'h32, 3'd5, 5'b11100}, '{8'h33, 3'd5, 5'b11000},
    '{8'h34, 3'd5, 5'b10000}, '{8'h35, 3'd5, 5'b00000}, '{8'h36, 3'd5, 5'b00001},
    '{8'h37, 3'd5, 5'b00011}, '{8'h38, 3'd5, 5'b00111}, '{8'h39, 3'd5, 5'b01111}
  };

  // Command from front to back: symbols first, then up to two plain chars
  typedef struct packed {
    logic [4:0] sym_pat;
    logic [2:0] sym_len;
    logic [1:0] n_chr;
    logic [7:0] c0;
    logic [7:0] c1;
    logic       flag;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       flag;
  } out_item_t;

  // Character to code; len is zero for an unknown character
  function automatic code_ent_t enc_lookup(input logic [7:0] ch);
    code_ent_t res;
    res = '0;
    for (int i = 0; i < NUM_CODES; i++) begin
      if (CODE_TAB[i].ch == ch) begin
        res = CODE_TAB[i];
      end
    end
    return res;
  endfunction

  // Code to character; '?' when no entry matches
  function automatic logic [7:0] dec_lookup(input logic [4:0] pat, input logic [2:0] len);
    logic [7:0] res;
    res = CH_QUEST;
    for (int i = 0; i < NUM_CODES; i++) begin
      if (CODE_TAB[i].len == len && CODE_TAB[i].pat == pat) begin
        res = CODE_TAB[i].ch;
      end
    end
    return res;
  endfunction

endpackage

FILE: rtl/morse_codec_stream_top.sv
// Channel  Direction  Ports                                      Accepted when
// input    in         in_push, in_full, in_char_in, in_end_of_text  in_push && !in_full
// result   out        out_pop, out_empty, out_char_out, out_last, out_invalid_seen
//                                                                  out_pop && !out_empty
// config   in         cfg_valid, cfg_ready, cfg_direction        cfg_valid && cfg_ready
//
// An item is classified in the cycle it is accepted and queued as at most one command.
// The back end emits one result per cycle while the result queue is not full; an item
// yields 1 to 6 results, and items with no result only take the input handshake.
// Sustained rate is set by the back end's result sequencer.
// Reset is synchronous on rst_n and empties both queues and clears line state.
// in_full rises when the command queue is full; out_pop stalls hold the back end.
module morse_codec_stream_top #(
  parameter int unsigned MAX_SYMBOLS = 5,
  parameter int unsigned CMD_DEPTH   = 2,
  parameter int unsigned OUT_DEPTH   = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_char_in,
  input  logic       in_end_of_text,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_char_out,
  output logic       out_last,
  output logic       out_invalid_seen,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_direction
);

  logic               accept;
  logic               cmd_push;
  mcs_pkg::cmd_t      cmd_in, cmd_head;
  logic               cmd_empty, cmd_pop;
  logic               res_push, res_full;
  mcs_pkg::out_item_t res_item, res_head;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !in_full;

  mcs_front #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_dir    (cfg_direction),
    .accept     (accept),
    .char_in    (in_char_in),
    .end_of_text(in_end_of_text),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  // command queue between front and back
  mcs_fifo #(
    .WIDTH($bits(mcs_pkg::cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (accept && cmd_push),
    .wdata(cmd_in),
    .full (in_full),
    .pop  (cmd_pop),
    .rdata(cmd_head),
    .empty(cmd_empty)
  );

  mcs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_empty(cmd_empty),
    .cmd      (cmd_head),
    .cmd_pop  (cmd_pop),
    .out_full (res_full),
    .out_push (res_push),
    .out_item (res_item)
  );

  // result queue toward the consumer
  mcs_fifo #(
    .WIDTH($bits(mcs_pkg::out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_item),
    .full (res_full),
    .pop  (out_pop),
    .rdata(res_head),
    .empty(out_empty)
  );

  assign out_char_out     = res_head.ch;
  assign out_last         = res_head.last;
  assign out_invalid_seen = res_head.flag;

endmodule

FILE: rtl/mcs_fifo.sv
module mcs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/mcs_front.sv
module mcs_front #(
  parameter int unsigned MAX_SYMBOLS = 5
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_dir,
  input  logic         accept,
  input  logic [7:0]   char_in,
  input  logic         end_of_text,
  output logic         cmd_push,
  output mcs_pkg::cmd_t cmd
);

  localparam int unsigned PW = MAX_SYMBOLS;
  localparam int unsigned CW = $clog2(MAX_SYMBOLS + 2);

  logic          direction_r;
  logic [PW-1:0] pattern_r, pattern_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          bad_r, bad_nxt;
  logic          word_open_r, word_open_nxt;
  logic          invalid_r, invalid_nxt;

  logic              has_letter;
  logic [7:0]        dec_char;
  logic [7:0]        folded;
  mcs_pkg::code_ent_t enc_ent;

  // letter flush result
  assign has_letter = (count_r != '0) || bad_r;
  always_comb begin
    if (!bad_r && count_r <= CW'(mcs_pkg::CODE_MAX_LEN) && count_r <= CW'(MAX_SYMBOLS)) begin
      dec_char = mcs_pkg::dec_lookup(pattern_r[4:0], count_r[2:0]);
    end else begin
      dec_char = mcs_pkg::CH_QUEST;
    end
  end

  // upper-case folding and encode lookup
  assign folded  = (char_in >= mcs_pkg::CH_LC_A && char_in <= mcs_pkg::CH_LC_Z) ?
                   char_in - mcs_pkg::CASE_OFS : char_in;
  assign enc_ent = mcs_pkg::enc_lookup(folded);

  // classify the item and build its command
  always_comb begin
    logic flag_v;
    pattern_nxt   = pattern_r;
    count_nxt     = count_r;
    bad_nxt       = bad_r;
    word_open_nxt = word_open_r;
    flag_v        = invalid_r;
    cmd           = '0;
    cmd_push      = 1'b0;
    if (end_of_text) begin
      cmd_push = 1'b1;
      if (!direction_r) begin
        cmd.c0        = mcs_pkg::CH_NL;
        cmd.c1        = mcs_pkg::CH_NL;
        cmd.n_chr     = word_open_r ? 2'd2 : 2'd1;
        word_open_nxt = 1'b0;
      end else if (has_letter) begin
        cmd.c0      = dec_char;
        cmd.c1      = mcs_pkg::CH_NL;
        cmd.n_chr   = 2'd2;
        flag_v      = flag_v || (dec_char == mcs_pkg::CH_QUEST);
        pattern_nxt = '0;
        count_nxt   = '0;
        bad_nxt     = 1'b0;
      end else begin
        cmd.c0    = mcs_pkg::CH_NL;
        cmd.n_chr = 2'd1;
      end
    end else if (!direction_r) begin
      if (folded == mcs_pkg::CH_SPACE) begin
        if (word_open_r) begin
          cmd_push      = 1'b1;
          cmd.c0        = mcs_pkg::CH_NL;
          cmd.n_chr     = 2'd1;
          word_open_nxt = 1'b0;
        end
      end else begin
        cmd_push      = 1'b1;
        word_open_nxt = 1'b1;
        if (enc_ent.len != '0) begin
          cmd.sym_pat = enc_ent.pat;
          cmd.sym_len = enc_ent.len;
          cmd.c0      = mcs_pkg::CH_SPACE;
          cmd.n_chr   = 2'd1;
        end else begin
          cmd.c0    = mcs_pkg::CH_QUEST;
          cmd.c1    = mcs_pkg::CH_SPACE;
          cmd.n_chr = 2'd2;
          flag_v    = 1'b1;
        end
      end
    end else begin
      if (char_in == mcs_pkg::CH_SPACE || char_in == mcs_pkg::CH_SLASH) begin
        cmd_push = has_letter || (char_in == mcs_pkg::CH_SLASH);
        if (has_letter) begin
          cmd.c0      = dec_char;
          cmd.c1      = mcs_pkg::CH_SPACE;
          cmd.n_chr   = (char_in == mcs_pkg::CH_SLASH) ? 2'd2 : 2'd1;
          flag_v      = flag_v || (dec_char == mcs_pkg::CH_QUEST);
          pattern_nxt = '0;
          count_nxt   = '0;
          bad_nxt     = 1'b0;
        end else begin
          cmd.c0    = mcs_pkg::CH_SPACE;
          cmd.n_chr = 2'd1;
        end
      end else if (char_in == mcs_pkg::CH_DOT || char_in == mcs_pkg::CH_DASH) begin
        if (count_r < CW'(MAX_SYMBOLS)) begin
          if (char_in == mcs_pkg::CH_DASH) begin
            pattern_nxt = pattern_r | (PW'(1) << count_r);
          end
          count_nxt = count_r + 1'b1;
        end else begin
          count_nxt = CW'(MAX_SYMBOLS + 1);
        end
      end else begin
        bad_nxt = 1'b1;
      end
    end
    cmd.flag    = flag_v;
    invalid_nxt = end_of_text ? 1'b0 : flag_v;
  end

  // line state; a direction write clears it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      pattern_r   <= '0;
      count_r     <= '0;
      bad_r       <= 1'b0;
      word_open_r <= 1'b0;
      invalid_r   <= 1'b0;
    end else if (cfg_we) begin
      direction_r <= cfg_dir;
      pattern_r   <= '0;
      count_r     <= '0;
      bad_r       <= 1'b0;
      word_open_r <= 1'b0;
      invalid_r   <= 1'b0;
    end else if (accept) begin
      pattern_r   <= pattern_nxt;
      count_r     <= count_nxt;
      bad_r       <= bad_nxt;
      word_open_r <= word_open_nxt;
      invalid_r   <= invalid_nxt;
    end
  end

  // end item clears the sticky flag
  a_end_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && end_of_text && !cfg_we) |=> !invalid_r)
    else $error("invalid flag not cleared after end item");

  // symbol count saturates one past the limit
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SYMBOLS + 1))
    else $error("symbol count out of range");

  // decode mode never opens an encode word
  a_no_word_in_decode: assert property (@(posedge clk) disable iff (!rst_n)
    direction_r |-> !word_open_r)
    else $error("word open in decode mode");

endmodule

FILE: rtl/mcs_back.sv
module mcs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_empty,
  input  mcs_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  input  logic              out_full,
  output logic              out_push,
  output mcs_pkg::out_item_t out_item
);

  logic          busy_r;
  logic [2:0]    step_r;
  mcs_pkg::cmd_t cur_r;
  logic [2:0]    total;
  logic          is_last;

  assign total    = cur_r.sym_len + {1'b0, cur_r.n_chr};
  assign is_last  = (step_r == total - 3'd1);
  assign out_push = busy_r && !out_full;
  assign cmd_pop  = !cmd_empty && (!busy_r || (out_push && is_last));

  // character for the current step
  always_comb begin
    out_item.last = is_last;
    out_item.flag = cur_r.flag;
    if (step_r < cur_r.sym_len) begin
      out_item.ch = cur_r.sym_pat[step_r] ? mcs_pkg::CH_DASH : mcs_pkg::CH_DOT;
    end else if (step_r == cur_r.sym_len) begin
      out_item.ch = cur_r.c0;
    end else begin
      out_item.ch = cur_r.c1;
    end
  end

  // step sequencer, one char per cycle unless the result queue is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (cmd_pop) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (out_push) begin
      if (is_last) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_r <= cmd;
    end
  end

endmodule
